FILE: sv/wce_pkg.sv
// Shared types and constants of the wall collision event tracker.
// Used by all modules of the block; depends on nothing.
`timescale 1ns / 1ps

package wce_pkg;

    localparam int ATOM_SLOTS_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PADDR_W        = 5;

    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

    localparam logic REC_ENTRY = 1'b0;
    localparam logic REC_EXIT  = 1'b1;

    // Register indexes on the configuration port (byte address 4*index)
    localparam logic [2:0] REG_GAS_SPECIES     = 3'd0;
    localparam logic [2:0] REG_CHANNEL_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CUTOFF_DISTANCE = 3'd2;
    localparam logic [2:0] REG_CHANNEL_X_LOW   = 3'd3;
    localparam logic [2:0] REG_CHANNEL_X_HIGH  = 3'd4;

    typedef struct packed {
        logic [11:0]        atom_slot;
        logic [7:0]         atom_kind;
        logic               first_frame;
        logic [23:0]        frame_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } in_item_t;

    typedef struct packed {
        logic               record_kind;
        logic [11:0]        particle_slot;
        logic [23:0]        snap_frame;
        logic signed [31:0] snap_x;
        logic signed [31:0] snap_y;
        logic signed [31:0] snap_z;
        logic signed [31:0] snap_vx;
        logic signed [31:0] snap_vy;
        logic signed [31:0] snap_vz;
        logic               pair_last;
        logic [23:0]        started_total;
        logic [23:0]        ended_total;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         gas_species;
        logic [30:0]        channel_height;
        logic [30:0]        cutoff_distance;
        logic signed [31:0] channel_x_low;
        logic signed [31:0] channel_x_high;
    } cfg_t;

    // One stored snapshot of a particle
    typedef struct packed {
        logic [23:0]        frame;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } snap_t;

    // Classified record passed from the front end to the back end
    typedef struct packed {
        logic [11:0] slot;
        logic        first;
        logic        high;
        snap_t       rec;
    } q_item_t;

endpackage

FILE: sv/wall_collision_event_tracker.sv
// A record is read from the slot memories once it heads wce_queue and the back end is idle;
// the entry snapshot of an exit pair goes to the m_ output register in the EXEC state.
// Each record passes IDLE and EXEC, set by the read-then-write of the per-slot memories in
// the back end; one ending a collision also passes OUT0 and OUT1, held while m_ready is low.
// Reset: synchronous, active low; then the flag memory is cleared slot by slot, while
// s_ready stays low. Configuration writes are taken throughout.
`timescale 1ns / 1ps

module wall_collision_event_tracker #(
    parameter int ATOM_SLOTS = wce_pkg::ATOM_SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wce_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wce_pkg::out_item_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wce_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    wce_pkg::cfg_t    cfg_reg;
    wce_pkg::q_item_t push_data;
    wce_pkg::q_item_t head;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic             clearing;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gas_species     <= 8'd1;
            cfg_reg.channel_height  <= '0;
            cfg_reg.cutoff_distance <= '0;
            cfg_reg.channel_x_low   <= '0;
            cfg_reg.channel_x_high  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                wce_pkg::REG_GAS_SPECIES:     cfg_reg.gas_species     <= pwdata[7:0];
                wce_pkg::REG_CHANNEL_HEIGHT:  cfg_reg.channel_height  <= pwdata[30:0];
                wce_pkg::REG_CUTOFF_DISTANCE: cfg_reg.cutoff_distance <= pwdata[30:0];
                wce_pkg::REG_CHANNEL_X_LOW:   cfg_reg.channel_x_low   <= $signed(pwdata);
                wce_pkg::REG_CHANNEL_X_HIGH:  cfg_reg.channel_x_high  <= $signed(pwdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wce_pkg::REG_GAS_SPECIES:     prdata = {24'd0, cfg_reg.gas_species};
            wce_pkg::REG_CHANNEL_HEIGHT:  prdata = {1'b0, cfg_reg.channel_height};
            wce_pkg::REG_CUTOFF_DISTANCE: prdata = {1'b0, cfg_reg.cutoff_distance};
            wce_pkg::REG_CHANNEL_X_LOW:   prdata = cfg_reg.channel_x_low;
            wce_pkg::REG_CHANNEL_X_HIGH:  prdata = cfg_reg.channel_x_high;
            default:                      prdata = '0;
        endcase
    end

    wce_front #(
        .ATOM_SLOTS(ATOM_SLOTS)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .push_data(push_data)
    );

    wce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    wce_back #(
        .ATOM_SLOTS(ATOM_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    a_no_input_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clearing |-> !s_ready
    ) else $error("input taken during flag clearing pass");

    a_no_output_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clearing |-> !m_valid
    ) else $error("result shown during flag clearing pass");

    a_pair_follows_entry: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.pair_last)
            |=> (m_valid && m_data.pair_last
                 && (m_data.record_kind == wce_pkg::REC_EXIT))
    ) else $error("entry snapshot not followed by exit record");

    a_pop_only_when_filled: assert property (
        @(posedge aclk) disable iff (!aresetn) pop |-> !q_empty && !clearing
    ) else $error("queue popped while empty or clearing");
`endif

endmodule

FILE: sv/wce_front.sv
// Front end: accepts input records and keeps only tracked in-channel ones.
// Depends on wce_pkg; feeds wce_queue.
`timescale 1ns / 1ps

module wce_front #(
    parameter int ATOM_SLOTS = wce_pkg::ATOM_SLOTS_DEF
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  wce_pkg::in_item_t s_data,
    input  wce_pkg::cfg_t     cfg,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output wce_pkg::q_item_t  push_data
);

    logic slot_ok;
    logic kind_ok;
    logic z_ok;
    logic x_ok;
    logic qualify;

    assign s_ready = !q_full && !clearing;

    always_comb begin
        slot_ok = 32'(s_data.atom_slot) < ATOM_SLOTS;
        kind_ok = s_data.atom_kind == cfg.gas_species;
        z_ok    = (s_data.pos_z >= 32'sd0)
                  && (s_data.pos_z <= $signed({1'b0, cfg.channel_height}));
        x_ok    = (s_data.pos_x >= cfg.channel_x_low)
                  && (s_data.pos_x <= cfg.channel_x_high);
        qualify = slot_ok && kind_ok && z_ok && x_ok;
    end

    // Drop records that do not qualify; they change nothing downstream
    assign push = s_valid && s_ready && qualify;

    always_comb begin
        push_data.slot      = s_data.atom_slot;
        push_data.first     = s_data.first_frame;
        push_data.high      = s_data.pos_z >= $signed({1'b0, cfg.cutoff_distance});
        push_data.rec.frame = s_data.frame_index;
        push_data.rec.px    = s_data.pos_x;
        push_data.rec.py    = s_data.pos_y;
        push_data.rec.pz    = s_data.pos_z;
        push_data.rec.vx    = s_data.vel_x;
        push_data.rec.vy    = s_data.vel_y;
        push_data.rec.vz    = s_data.vel_z;
    end

endmodule

FILE: sv/wce_queue.sv
// Short FIFO of classified records between the front and back ends.
// Depends on wce_pkg.
`timescale 1ns / 1ps

module wce_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wce_pkg::q_item_t push_data,
    output logic             full,
    input  logic             pop,
    output wce_pkg::q_item_t head,
    output logic             empty
);

    localparam int DEPTH = wce_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wce_pkg::q_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/wce_back.sv
// Back end: per-slot flag and snapshot memories, collision sequencing, counters
// and the output register. Depends on wce_pkg; fed by wce_queue.
`timescale 1ns / 1ps

module wce_back #(
    parameter int ATOM_SLOTS = wce_pkg::ATOM_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  wce_pkg::q_item_t   head,
    output logic               pop,
    output logic               clearing,
    output logic               m_valid,
    input  logic               m_ready,
    output wce_pkg::out_item_t m_data
);

    localparam int SLOT_AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_OUT0  = 5'b01000,
        ST_OUT1  = 5'b10000
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [SLOT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [23:0]        started_cnt_reg, started_cnt_next;
    logic [23:0]        ended_cnt_reg, ended_cnt_next;
    logic               m_valid_reg, m_valid_next;
    wce_pkg::out_item_t m_data_reg, m_data_next;
    wce_pkg::q_item_t   item_reg;

    // Flag memory entry: {armed, colliding}
    logic [1:0]         flag_mem  [ATOM_SLOTS];
    wce_pkg::snap_t     last_mem  [ATOM_SLOTS];
    wce_pkg::snap_t     entry_mem [ATOM_SLOTS];
    logic [1:0]         flag_rd_reg;
    wce_pkg::snap_t     last_rd_reg;
    wce_pkg::snap_t     entry_rd_reg;

    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] wr_addr;
    logic               flag_we;
    logic [SLOT_AW-1:0] flag_waddr;
    logic [1:0]         flag_wdata;
    logic               last_we;
    logic               entry_we;

    logic               armed_n;
    logic               coll_n;
    logic               start_hit;
    logic               end_hit;

    assign clearing = state_reg == ST_CLEAR;
    assign rd_en    = (state_reg == ST_IDLE) && !q_empty;
    assign pop      = rd_en;
    assign rd_addr  = SLOT_AW'(head.slot);
    assign wr_addr  = SLOT_AW'(item_reg.slot);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Slot update rule on the flags read for the record in hand
    always_comb begin
        armed_n   = flag_rd_reg[1];
        coll_n    = flag_rd_reg[0];
        start_hit = 1'b0;
        end_hit   = 1'b0;
        if (item_reg.first) begin
            if (item_reg.high) begin
                armed_n = 1'b1;
            end
        end else if (!item_reg.high) begin
            start_hit = flag_rd_reg[1];
            if (flag_rd_reg[1]) begin
                coll_n = 1'b1;
            end
            armed_n = 1'b0;
        end else begin
            end_hit = flag_rd_reg[0];
            coll_n  = 1'b0;
            armed_n = 1'b1;
        end
    end

    always_comb begin
        flag_we    = (state_reg == ST_CLEAR) || (state_reg == ST_EXEC);
        flag_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wr_addr;
        flag_wdata = (state_reg == ST_CLEAR) ? 2'b00 : {armed_n, coll_n};
        last_we    = state_reg == ST_EXEC;
        entry_we   = (state_reg == ST_EXEC) && start_hit;
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        started_cnt_next = started_cnt_reg;
        ended_cnt_next   = ended_cnt_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SLOT_AW'(ATOM_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (start_hit && (started_cnt_reg != wce_pkg::CNT_MAX)) begin
                    started_cnt_next = started_cnt_reg + 1'b1;
                end
                if (end_hit && (ended_cnt_reg != wce_pkg::CNT_MAX)) begin
                    ended_cnt_next = ended_cnt_reg + 1'b1;
                end
                if (end_hit) begin
                    m_valid_next               = 1'b1;
                    m_data_next.record_kind    = wce_pkg::REC_ENTRY;
                    m_data_next.particle_slot  = item_reg.slot;
                    m_data_next.snap_frame     = entry_rd_reg.frame;
                    m_data_next.snap_x         = entry_rd_reg.px;
                    m_data_next.snap_y         = entry_rd_reg.py;
                    m_data_next.snap_z         = entry_rd_reg.pz;
                    m_data_next.snap_vx        = entry_rd_reg.vx;
                    m_data_next.snap_vy        = entry_rd_reg.vy;
                    m_data_next.snap_vz        = entry_rd_reg.vz;
                    m_data_next.pair_last      = 1'b0;
                    m_data_next.started_total  = started_cnt_next;
                    m_data_next.ended_total    = ended_cnt_next;
                    state_next                 = ST_OUT0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT0: begin
                // Follow the entry snapshot with the current record
                if (m_ready) begin
                    m_data_next.record_kind    = wce_pkg::REC_EXIT;
                    m_data_next.particle_slot  = item_reg.slot;
                    m_data_next.snap_frame     = item_reg.rec.frame;
                    m_data_next.snap_x         = item_reg.rec.px;
                    m_data_next.snap_y         = item_reg.rec.py;
                    m_data_next.snap_z         = item_reg.rec.pz;
                    m_data_next.snap_vx        = item_reg.rec.vx;
                    m_data_next.snap_vy        = item_reg.rec.vy;
                    m_data_next.snap_vz        = item_reg.rec.vz;
                    m_data_next.pair_last      = 1'b1;
                    m_data_next.started_total  = started_cnt_reg;
                    m_data_next.ended_total    = ended_cnt_reg;
                    state_next                 = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            started_cnt_reg <= '0;
            ended_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            started_cnt_reg <= started_cnt_next;
            ended_cnt_reg   <= ended_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (rd_en) begin
            item_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (rd_en) begin
            flag_rd_reg <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (last_we) begin
            last_mem[wr_addr] <= item_reg.rec;
        end
        if (rd_en) begin
            last_rd_reg <= last_mem[rd_addr];
        end
    end

    // Entry snapshot takes the last snapshot as it stood before this record
    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[wr_addr] <= last_rd_reg;
        end
        if (rd_en) begin
            entry_rd_reg <= entry_mem[rd_addr];
        end
    end

endmodule
